@@ hdl/dq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// request codes, status codes and the result record shared by the deque blocks
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_REAR   = 3'd3;
    localparam logic [2:0] REQ_LIST       = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNDER = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic signed [31:0] value;
        logic        [1:0]  status;
        logic               last;
    } t_result;

endpackage

@@ hdl/double_ended_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// bounded deque of signed 32-bit values in a circular slot memory
// ----------------------------------------------------------------------------
// One request is handled at a time. For a pop or a list the transfer cycle
// issues the slot memory read; in S_EXEC, once the output register is free,
// the block writes the slot or returns the read value and updates head and
// count. A list of n stored elements does one slot memory read per element
// through the single read port; an empty list or a full push gives a single
// status result, and an unused request code gives no result. While the output
// register is held by back-pressure, the block waits in S_EXEC.
// Slots need no clearing after reset, read data of unwritten slots is never returned.
module double_ended_queue #(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic        [2:0]  i_req_type,
    input  logic signed [31:0] i_push_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_value,
    output logic        [1:0]  o_status,
    output logic               o_is_last
);

    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic               r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [2:0]         r_req;
    logic signed [31:0] r_val;
    logic [AW-1:0]      r_off, n_off;

    logic               w_accept;
    logic               w_free;
    logic               w_load;
    t_result            w_result;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic signed [31:0] w_rdata;
    logic               w_full;
    logic               w_empty;
    logic [AW-1:0]      w_count_m1;
    logic               w_list_last;
    logic               w_push_ok;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_count_m1  = r_count[AW-1:0] - AW'(1);
    assign w_list_last = (CW'(r_off) + CW'(1) == r_count);
    assign w_load      = (r_state == S_EXEC) && w_free;
    assign w_push_ok   = w_load && !w_full
                         && (r_req == REQ_PUSH_FRONT || r_req == REQ_PUSH_REAR);

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_off    = r_off;
        w_we     = 1'b0;
        w_waddr  = f_wrap(r_head, r_count[AW-1:0]);
        w_re     = 1'b0;
        w_raddr  = r_head;
        w_result = '{value: '0, status: ST_OK, last: 1'b1};

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_off = '0;
                    case (i_req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                            n_state = S_EXEC;
                        end
                        REQ_POP_FRONT, REQ_LIST: begin
                            w_re    = 1'b1;
                            w_raddr = r_head;
                            n_state = S_EXEC;
                        end
                        REQ_POP_REAR: begin
                            w_re    = 1'b1;
                            w_raddr = f_wrap(r_head, w_count_m1);
                            n_state = S_EXEC;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                if (w_free) begin
                    n_state = S_IDLE;
                    case (r_req)
                        REQ_PUSH_FRONT: begin
                            if (w_full) begin
                                w_result.status = ST_OVER;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = (r_head == '0) ? AW'(DEPTH - 1)
                                                         : r_head - AW'(1);
                                n_head  = w_waddr;
                                n_count = r_count + CW'(1);
                            end
                        end
                        REQ_PUSH_REAR: begin
                            if (w_full) begin
                                w_result.status = ST_OVER;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = f_wrap(r_head, r_count[AW-1:0]);
                                n_count = r_count + CW'(1);
                            end
                        end
                        REQ_POP_FRONT: begin
                            if (w_empty) begin
                                w_result.status = ST_UNDER;
                            end else begin
                                w_result.value = w_rdata;
                                n_head  = f_wrap(r_head, AW'(1));
                                n_count = r_count - CW'(1);
                            end
                        end
                        REQ_POP_REAR: begin
                            if (w_empty) begin
                                w_result.status = ST_UNDER;
                            end else begin
                                w_result.value = w_rdata;
                                n_count = r_count - CW'(1);
                            end
                        end
                        default: begin
                            if (w_empty) begin
                                w_result.status = ST_EMPTY;
                            end else begin
                                w_result.value = w_rdata;
                                w_result.last  = w_list_last;
                                if (!w_list_last) begin
                                    // fetch the next element while this one leaves
                                    n_off   = r_off + AW'(1);
                                    w_re    = 1'b1;
                                    w_raddr = f_wrap(r_head, n_off);
                                    n_state = S_EXEC;
                                end
                            end
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_off   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_off   <= n_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req_type;
            r_val <= i_push_value;
        end
    end

    dq_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_val),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dq_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_result    (w_result),
        .o_free      (w_free),
        .o_valid     (o_valid),
        .o_out_value (o_out_value),
        .o_status    (o_status),
        .o_is_last   (o_is_last),
        .i_ready     (i_ready)
    );

    // count stays within the slot capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("deque count beyond capacity");

    // a successful push grows the count by exactly one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_ok |=> r_count == $past(r_count) + CW'(1))
        else $error("push did not raise count");

    // slot writes and reads never share a cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_we && w_re))
        else $error("slot read and write in the same cycle");

    // no result is loaded while a request is being taken
    a_load_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_load)
        else $error("result loaded during request transfer");

endmodule

@@ hdl/dq_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_mem
// slot storage: one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module dq_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [31:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic signed [31:0] o_rdata
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/dq_obuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_obuf
// result output register, holds the control side while a result waits untaken
// ----------------------------------------------------------------------------
module dq_obuf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  dq_pkg::t_result    i_result,
    output logic               o_free,
    output logic               o_valid,
    output logic signed [31:0] o_out_value,
    output logic        [1:0]  o_status,
    output logic               o_is_last,
    input  logic               i_ready
);

    import dq_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_value = r_result.value;
    assign o_status    = r_result.status;
    assign o_is_last   = r_result.last;

endmodule

@@ tb/deque_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_result_checker
// Watches both channels of the deque. Every request transfer updates a
// private copy of the deque and queues the results it must cause. Every
// result transfer is compared field by field with the oldest queued result.
// ----------------------------------------------------------------------------
module deque_result_checker #(
    parameter int DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               o_ready,
    input  logic        [2:0]  i_req_type,
    input  logic signed [31:0] i_push_value,
    input  logic               o_valid,
    input  logic               i_ready,
    input  logic signed [31:0] o_out_value,
    input  logic        [1:0]  o_status,
    input  logic               o_is_last,
    output int                 o_error_count,
    output int                 o_pending
);

    import dq_pkg::*;

    localparam int HW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [31:0] slot_copy [DEPTH];
    logic [HW-1:0]      front_slot;
    logic [CW-1:0]      stored;
    t_result            owed_results [$];
    t_result            want;
    int                 errors = 0;

    function automatic logic [HW-1:0] slot_of(input int offset);
        return HW'((int'(front_slot) + offset) % DEPTH);
    endfunction

    function automatic t_result make_result(input logic signed [31:0] value,
                                            input logic [1:0] status,
                                            input logic last);
        t_result r;
        r.value  = value;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    task automatic apply_request(input logic [2:0] req, input logic signed [31:0] val);
        int i;
        case (req)
            REQ_PUSH_FRONT: begin
                if (stored == CW'(DEPTH)) begin
                    owed_results.push_back(make_result('0, ST_OVER, 1'b1));
                end else begin
                    front_slot = (front_slot == '0) ? HW'(DEPTH - 1)
                                                    : front_slot - HW'(1);
                    slot_copy[front_slot] = val;
                    stored = stored + CW'(1);
                    owed_results.push_back(make_result('0, ST_OK, 1'b1));
                end
            end
            REQ_PUSH_REAR: begin
                if (stored == CW'(DEPTH)) begin
                    owed_results.push_back(make_result('0, ST_OVER, 1'b1));
                end else begin
                    slot_copy[slot_of(int'(stored))] = val;
                    stored = stored + CW'(1);
                    owed_results.push_back(make_result('0, ST_OK, 1'b1));
                end
            end
            REQ_POP_FRONT: begin
                if (stored == '0) begin
                    owed_results.push_back(make_result('0, ST_UNDER, 1'b1));
                end else begin
                    owed_results.push_back(make_result(slot_copy[front_slot], ST_OK, 1'b1));
                    front_slot = (front_slot == HW'(DEPTH - 1)) ? '0
                                                                : front_slot + HW'(1);
                    stored = stored - CW'(1);
                end
            end
            REQ_POP_REAR: begin
                if (stored == '0) begin
                    owed_results.push_back(make_result('0, ST_UNDER, 1'b1));
                end else begin
                    owed_results.push_back(make_result(slot_copy[slot_of(int'(stored) - 1)],
                                                       ST_OK, 1'b1));
                    stored = stored - CW'(1);
                end
            end
            REQ_LIST: begin
                if (stored == '0) begin
                    owed_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                end else begin
                    for (i = 0; i < int'(stored); i++) begin
                        owed_results.push_back(make_result(slot_copy[slot_of(i)], ST_OK,
                                                           i + 1 == int'(stored)));
                    end
                end
            end
            default: begin
                // unused codes leave the deque untouched
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_slot = '0;
            stored     = '0;
            owed_results.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result transfer with none owed: out_value %0d status %0d",
                           o_out_value, o_status);
                    errors++;
                end else begin
                    want = owed_results.pop_front();
                    if (o_out_value !== want.value) begin
                        $error("out_value: expected %0d, actual %0d", want.value, o_out_value);
                        errors++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        errors++;
                    end
                    if (o_is_last !== want.last) begin
                        $error("is_last: expected %0d, actual %0d", want.last, o_is_last);
                        errors++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                apply_request(i_req_type, i_push_value);
            end
        end
        o_error_count <= errors;
        o_pending     <= owed_results.size();
    end

endmodule

@@ tb/double_ended_queue_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Drives push, pop and list requests into the deque: a directed opening on
// empty, wrapped and extreme-value cases, then random fill, drain and mixed
// phases that reach full and empty, with random idling on both channels.
// ----------------------------------------------------------------------------
module double_ended_queue_test;

    import dq_pkg::*;

    localparam int DEPTH        = 32;
    localparam int RANDOM_ITEMS = 360;
    localparam int QUIET_ITEMS  = 60;
    localparam int CYCLE_LIMIT  = 1000000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic        [2:0]  i_req_type = REQ_PUSH_FRONT;
    logic signed [31:0] i_push_value = 32'sd0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_out_value;
    logic        [1:0]  o_status;
    logic               o_is_last;

    int   error_count;
    int   pending;
    int   cycle_count = 0;
    int   stall_left = 0;
    logic quiet = 1'b0;

    double_ended_queue #(
        .DEPTH(DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_push_value(i_push_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_value (o_out_value),
        .o_status    (o_status),
        .o_is_last   (o_is_last)
    );

    deque_result_checker #(
        .DEPTH(DEPTH)
    ) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_value  (o_out_value),
        .o_status     (o_status),
        .o_is_last    (o_is_last),
        .o_error_count(error_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $error("cycle limit of %0d reached", CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure in bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_request(input logic [2:0] req, input logic signed [31:0] val);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_req_type   = req;
        i_push_value = val;
        i_valid      = 1'b1;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        logic [2:0] req;
        int         counted;
        int         block_left;
        int         mode;
        int         pick;
        int         push_odds;

        counted    = 0;
        block_left = 0;
        mode       = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty deque cases and unused codes
        send_request(REQ_POP_FRONT, random_value());
        send_request(REQ_POP_REAR, random_value());
        send_request(REQ_LIST, random_value());
        send_request(3'd5, random_value());
        send_request(3'd6, random_value());
        send_request(3'd7, random_value());
        // front push wraps the head below slot zero
        send_request(REQ_PUSH_FRONT, 32'sh7fffffff);
        send_request(REQ_PUSH_FRONT, 32'sh80000000);
        send_request(REQ_PUSH_REAR, 32'sd0);
        send_request(REQ_PUSH_REAR, -32'sd1);
        send_request(REQ_LIST, random_value());
        send_request(REQ_POP_FRONT, random_value());
        send_request(REQ_POP_REAR, random_value());
        send_request(REQ_PUSH_REAR, 32'sh55555555);
        send_request(REQ_PUSH_FRONT, 32'shaaaaaaaa);
        send_request(REQ_LIST, random_value());
        send_request(REQ_POP_FRONT, random_value());
        send_request(REQ_POP_FRONT, random_value());
        send_request(REQ_POP_REAR, random_value());
        // single element left, pop it from the rear
        send_request(REQ_POP_REAR, random_value());
        send_request(REQ_POP_FRONT, random_value());
        send_request(REQ_LIST, random_value());

        // fill, drain and mixed phases
        while (counted < RANDOM_ITEMS) begin
            if (block_left == 0) begin
                mode       = $urandom_range(0, 2);
                block_left = 48;
            end
            quiet = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
            pick  = $urandom_range(0, 99);
            if (pick < 3) begin
                req = 3'($urandom_range(5, 7));
            end else if (pick < 11) begin
                req = REQ_LIST;
            end else begin
                push_odds = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
                if ($urandom_range(0, 99) < push_odds) begin
                    req = $urandom_range(0, 1) ? REQ_PUSH_REAR : REQ_PUSH_FRONT;
                end else begin
                    req = $urandom_range(0, 1) ? REQ_POP_REAR : REQ_POP_FRONT;
                end
            end
            send_request(req, random_value());
            if (req <= REQ_LIST) begin
                counted++;
                block_left--;
            end
        end

        i_valid = 1'b0;
        quiet   = 1'b1;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
